@@ hw/rtl/ght_pkg.sv @@
// ----------------------------------------------------------------------------
// ght_pkg
// Shared codes and sizes for the generational handle table.
// ----------------------------------------------------------------------------
package ght_pkg;

    // Request kinds (slave tuser)
    localparam logic [1:0] KIND_ALLOC    = 2'd0;
    localparam logic [1:0] KIND_VALIDATE = 2'd1;
    localparam logic [1:0] KIND_FREE     = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_EXHAUSTED = 2'd2;
    localparam logic [1:0] ST_UNKNOWN   = 2'd3;

    // Live bits are searched one word of this many slots at a time
    localparam int WORD_BITS = 32;
    localparam int WORD_LSB  = 5;

    localparam int IN_DATA_BITS  = 64;
    localparam int IN_USER_BITS  = 2;
    localparam int OUT_DATA_BITS = 80;
    localparam int HANDLE_BITS   = 63;
    localparam int INDEX_BITS    = 9;

endpackage

@@ hw/rtl/generational_handle_table_top.sv @@
// ----------------------------------------------------------------------------
// generational_handle_table_top
// Slot table with live bits and per-slot generations; allocate, validate, free.
// ----------------------------------------------------------------------------
// Each request beat (tuser = kind, tdata = handle) produces exactly one result
// beat. A request steps through its accept cycle, S_READ and S_RES until its
// result is loaded into the output register; no new request is taken
// until the one before is done: the accept cycle decodes the
// handle and picks the lowest word with a free slot, the next cycle encodes
// the free slot and reads the generation RAM, the last one forms the result
// and writes the generation and live bit back. A result held by a stalled
// master side holds the table in that last step. Live bits sit in flops;
// generations sit in one synchronous RAM. Slots are always claimed lowest
// first, so a fill count marks which RAM entries were ever written and the
// rest read as generation zero: no clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module generational_handle_table_top #(
    parameter int SLOT_COUNT      = 512,
    parameter int SLOT_FIELD_BITS = 11
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,   // [63:0] handle
    input  logic [1:0]  i_s_tuser,   // [1:0] kind
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [79:0] o_m_tdata    // [1:0] status, [64:2] new_handle,
                                     // [73:65] slot_index, [79:74] zero
);

    localparam int SB  = $clog2(SLOT_COUNT);
    localparam int SP  = SB + 1;
    localparam int GW  = ght_pkg::HANDLE_BITS - SLOT_FIELD_BITS;
    localparam int HW  = $clog2(SLOT_COUNT + 1);
    localparam int CW  = 17;
    localparam logic [ght_pkg::HANDLE_BITS-1:0] FieldMask =
        (ght_pkg::HANDLE_BITS'(1) << SLOT_FIELD_BITS) - ght_pkg::HANDLE_BITS'(1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_RES  = 2'd2;

    logic [1:0]            r_state, n_state;
    logic [1:0]            r_kind;
    logic                  r_hok;
    logic [SB-1:0]         r_hslot;
    logic [GW-1:0]         r_hgen;
    logic [SB-1:0]         r_slot;
    logic                  r_found;
    logic                  r_below;
    logic [SLOT_COUNT-1:0] r_live;
    logic [HW-1:0]         r_hw;
    logic                  r_out_valid;
    logic [79:0]           r_out_data;

    logic                  accept;
    logic [SLOT_FIELD_BITS-1:0] in_field;
    logic [GW-1:0]         in_gen;
    logic                  in_ok;
    logic [SB-1:0]         in_slot;

    logic                  find_found;
    logic [SB-1:0]         find_slot;
    logic [SB-1:0]         rd_addr;
    logic                  rd_en;
    logic [GW-1:0]         rd_data;

    logic                  out_free;
    logic                  commit;
    logic [GW-1:0]         gen_cur;
    logic [GW-1:0]         gen_new;
    logic [SP-1:0]         slot_p1;
    logic [1:0]            res_status;
    logic [ght_pkg::HANDLE_BITS-1:0] res_handle;
    logic                  res_ok;
    logic                  do_alloc;
    logic                  do_free;

    assign o_s_tready = (r_state == S_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;

    // handle decode on the incoming beat
    assign in_field = i_s_tdata[SLOT_FIELD_BITS-1:0];
    assign in_gen   = i_s_tdata[62:SLOT_FIELD_BITS];
    assign in_slot  = SB'(CW'(in_field) - CW'(1));
    assign in_ok    = !i_s_tdata[63] && (|in_field)
                   && (CW'(in_field) <= CW'(SLOT_COUNT)) && (|in_gen);

    ght_free_find #(
        .SLOT_COUNT (SLOT_COUNT),
        .SLOT_BITS  (SB)
    ) u_find (
        .i_clk   (i_clk),
        .i_load  (accept),
        .i_live  (r_live),
        .o_found (find_found),
        .o_slot  (find_slot)
    );

    assign rd_en   = (r_state == S_READ);
    assign rd_addr = (r_kind == ght_pkg::KIND_ALLOC) ? find_slot : r_hslot;

    ght_gen_ram #(
        .DEPTH     (SLOT_COUNT),
        .ADDR_BITS (SB),
        .DATA_BITS (GW)
    ) u_gen (
        .i_clk   (i_clk),
        .i_we    (do_alloc),
        .i_waddr (r_slot),
        .i_wdata (gen_new),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    // entries at or above the fill count were never written
    assign gen_cur  = r_below ? rd_data : '0;
    assign gen_new  = gen_cur + GW'(1);
    assign slot_p1  = SP'(r_slot) + SP'(1);
    assign out_free = !r_out_valid || i_m_tready;
    assign commit   = (r_state == S_RES) && out_free;

    always_comb begin
        res_status = ght_pkg::ST_UNKNOWN;
        res_handle = '0;
        res_ok     = 1'b0;
        case (r_kind) inside
            ght_pkg::KIND_ALLOC: begin
                if (!r_found) begin
                    res_status = ght_pkg::ST_FULL;
                end else if (&gen_cur) begin
                    res_status = ght_pkg::ST_EXHAUSTED;
                end else begin
                    res_status = ght_pkg::ST_OK;
                    res_ok     = 1'b1;
                    res_handle = (ght_pkg::HANDLE_BITS'(gen_new) << SLOT_FIELD_BITS)
                               | (ght_pkg::HANDLE_BITS'(slot_p1) & FieldMask);
                end
            end
            ght_pkg::KIND_VALIDATE, ght_pkg::KIND_FREE: begin
                if (r_hok && r_live[r_slot] && (gen_cur == r_hgen)) begin
                    res_status = ght_pkg::ST_OK;
                    res_ok     = 1'b1;
                end
            end
            default: begin
                res_status = ght_pkg::ST_UNKNOWN;
            end
        endcase
    end

    assign do_alloc = commit && res_ok && (r_kind == ght_pkg::KIND_ALLOC);
    assign do_free  = commit && res_ok && (r_kind == ght_pkg::KIND_FREE);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (accept) n_state = S_READ;
            S_READ:  n_state = S_RES;
            S_RES:   if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_live      <= '0;
            r_hw        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (do_alloc) begin
                r_live[r_slot] <= 1'b1;
                if (HW'(r_slot) == r_hw) begin
                    r_hw <= r_hw + HW'(1);
                end
            end
            if (do_free) begin
                r_live[r_slot] <= 1'b0;
            end
            if (commit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind  <= i_s_tuser;
            r_hok   <= in_ok;
            r_hslot <= in_slot;
            r_hgen  <= in_gen;
        end
        if (rd_en) begin
            r_slot  <= rd_addr;
            r_found <= find_found;
            r_below <= (HW'(rd_addr) < r_hw);
        end
        if (commit) begin
            r_out_data <= {6'b0,
                           res_ok ? ght_pkg::INDEX_BITS'(r_slot) : ght_pkg::INDEX_BITS'(0),
                           res_handle,
                           res_status};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

@@ hw/rtl/ght_gen_ram.sv @@
// ----------------------------------------------------------------------------
// ght_gen_ram
// Generation store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ght_gen_ram #(
    parameter int DEPTH     = 512,
    parameter int ADDR_BITS = 9,
    parameter int DATA_BITS = 52
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [ADDR_BITS-1:0] i_waddr,
    input  logic [DATA_BITS-1:0] i_wdata,
    input  logic                 i_re,
    input  logic [ADDR_BITS-1:0] i_raddr,
    output logic [DATA_BITS-1:0] o_rdata
);

    logic [DATA_BITS-1:0] r_mem [DEPTH];
    logic [DATA_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/ght_free_find.sv @@
// ----------------------------------------------------------------------------
// ght_free_find
// Lowest free slot search in two steps: on load, pick the lowest word that
// has a free slot and register it; the next cycle, encode the bit in it.
// ----------------------------------------------------------------------------
module ght_free_find #(
    parameter int SLOT_COUNT = 512,
    parameter int SLOT_BITS  = 9
) (
    input  logic                  i_clk,
    input  logic                  i_load,
    input  logic [SLOT_COUNT-1:0] i_live,
    output logic                  o_found,
    output logic [SLOT_BITS-1:0]  o_slot
);

    localparam int WORDS     = (SLOT_COUNT + ght_pkg::WORD_BITS - 1) / ght_pkg::WORD_BITS;
    localparam int WORD_IDX  = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int PAD_BITS  = WORDS * ght_pkg::WORD_BITS;

    logic [PAD_BITS-1:0]             live_pad;
    logic [ght_pkg::WORD_BITS-1:0]   words [WORDS];
    logic [WORDS-1:0]                word_has_free;
    logic [WORD_IDX-1:0]             n_word;
    logic                            n_any;
    logic [WORD_IDX-1:0]             r_word;
    logic                            r_any;
    logic [ght_pkg::WORD_BITS-1:0]   sel_word;
    logic [ght_pkg::WORD_LSB-1:0]    bit_idx;

    // slots past the end read as live so they are never picked
    always_comb begin
        live_pad = '1;
        live_pad[SLOT_COUNT-1:0] = i_live;
    end

    for (genvar w = 0; w < WORDS; w++) begin : g_word
        assign words[w]         = live_pad[w*ght_pkg::WORD_BITS +: ght_pkg::WORD_BITS];
        assign word_has_free[w] = ~&words[w];
    end

    always_comb begin
        n_word = '0;
        n_any  = 1'b0;
        for (int w = WORDS - 1; w >= 0; w--) begin
            if (word_has_free[w]) begin
                n_word = WORD_IDX'(w);
                n_any  = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_word <= n_word;
            r_any  <= n_any;
        end
    end

    assign sel_word = words[r_word];

    always_comb begin
        bit_idx = '0;
        for (int b = ght_pkg::WORD_BITS - 1; b >= 0; b--) begin
            if (!sel_word[b]) begin
                bit_idx = ght_pkg::WORD_LSB'(b);
            end
        end
    end

    assign o_found = r_any;
    assign o_slot  = SLOT_BITS'({r_word, bit_idx});

endmodule

@@ tb/ght_tb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ght_tb_pkg
// Request/result predictor and result scoreboard for the handle table bench.
// ----------------------------------------------------------------------------
package ght_tb_pkg;

    import ght_pkg::*;

    localparam int SLOTS      = 512;
    localparam int FIELD_BITS = 11;
    localparam int GEN_BITS   = HANDLE_BITS - FIELD_BITS;
    localparam logic [GEN_BITS-1:0] GEN_MAX = '1;

    // Kind code the block does not define
    localparam logic [1:0] KIND_RSVD = 2'd3;

    typedef struct packed {
        logic [1:0]             status;
        logic [HANDLE_BITS-1:0] new_handle;
        logic [INDEX_BITS-1:0]  slot_index;
    } table_result_t;

    function automatic logic [63:0] make_handle(input logic [GEN_BITS-1:0] gen,
                                                input logic [FIELD_BITS-1:0] field);
        return {1'b0, gen, field};
    endfunction

    class handle_table_sb;
        bit                  live[SLOTS];
        logic [GEN_BITS-1:0] gen_of[SLOTS];
        int                  live_q[$];
        table_result_t       expected_q[$];
        int                  errors;
        int                  n_req;
        int                  n_status[4];
        int                  n_alloc;
        int                  n_free;
        int                  peak_live;

        function new();
            for (int i = 0; i < SLOTS; i++) begin
                live[i]   = 1'b0;
                gen_of[i] = '0;
            end
            errors    = 0;
            n_req     = 0;
            n_alloc   = 0;
            n_free    = 0;
            peak_live = 0;
            for (int i = 0; i < 4; i++) n_status[i] = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Current handle of a random live slot, or the fallback if none is live
        function logic [63:0] any_live_handle(input logic [63:0] fallback);
            int s;
            if (live_q.size() == 0) return fallback;
            s = live_q[$urandom_range(live_q.size() - 1)];
            return make_handle(gen_of[s], FIELD_BITS'(s + 1));
        endfunction

        // Predict the result of an accepted request beat and update the table
        function void note_request(input logic [1:0] kind, input logic [63:0] handle);
            table_result_t           r;
            int                      s;
            logic [FIELD_BITS-1:0]   field;
            logic [GEN_BITS-1:0]     hgen;
            r.status     = ST_UNKNOWN;
            r.new_handle = '0;
            r.slot_index = '0;
            n_req++;
            if (kind == KIND_ALLOC) begin
                s = -1;
                for (int i = 0; i < SLOTS; i++) begin
                    if (!live[i]) begin
                        s = i;
                        break;
                    end
                end
                if (s < 0) begin
                    r.status = ST_FULL;
                end else if (gen_of[s] >= GEN_MAX) begin
                    r.status = ST_EXHAUSTED;
                end else begin
                    gen_of[s]++;
                    live[s] = 1'b1;
                    live_q.push_back(s);
                    if (live_q.size() > peak_live) peak_live = live_q.size();
                    n_alloc++;
                    r.status     = ST_OK;
                    r.new_handle = {gen_of[s], FIELD_BITS'(s + 1)};
                    r.slot_index = INDEX_BITS'(s);
                end
            end else if (kind == KIND_VALIDATE || kind == KIND_FREE) begin
                field = handle[FIELD_BITS-1:0];
                hgen  = handle[62:FIELD_BITS];
                if (!handle[63] && field != 0 && int'(field) <= SLOTS) begin
                    s = int'(field) - 1;
                    if (hgen != 0 && live[s] && gen_of[s] == hgen) begin
                        r.status     = ST_OK;
                        r.slot_index = INDEX_BITS'(s);
                        if (kind == KIND_FREE) begin
                            live[s] = 1'b0;
                            n_free++;
                            for (int k = 0; k < live_q.size(); k++) begin
                                if (live_q[k] == s) begin
                                    live_q.delete(k);
                                    break;
                                end
                            end
                        end
                    end
                end
            end
            expected_q.push_back(r);
        endfunction

        // tdata: [1:0] status, [64:2] new_handle, [73:65] slot_index, [79:74] zero
        function void check_result(input logic [OUT_DATA_BITS-1:0] beat);
            table_result_t e;
            if (expected_q.size() == 0) begin
                $error("result beat %h with no request outstanding", beat);
                errors++;
            end else begin
                e = expected_q.pop_front();
                n_status[e.status]++;
                if (beat[1:0] !== e.status) begin
                    $error("status: expected %0d, got %0d", e.status, beat[1:0]);
                    errors++;
                end
                if (beat[64:2] !== e.new_handle) begin
                    $error("new_handle: expected %h, got %h", e.new_handle, beat[64:2]);
                    errors++;
                end
                if (beat[73:65] !== e.slot_index) begin
                    $error("slot_index: expected %0d, got %0d", e.slot_index, beat[73:65]);
                    errors++;
                end
                if (beat[79:74] !== '0) begin
                    $error("pad: expected 0, got %h", beat[79:74]);
                    errors++;
                end
            end
        endfunction
    endclass

endpackage

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stream-level bench for generational_handle_table_top: directed edge cases,
// then random allocate/validate/free traffic under varying backpressure.
// ----------------------------------------------------------------------------
module tb;

    import ght_pkg::*;
    import ght_tb_pkg::*;

    localparam int CLK_HALF       = 6;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 12;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_s_tvalid;
    logic                     o_s_tready;
    logic [IN_DATA_BITS-1:0]  i_s_tdata;   // [63:0] handle
    logic [IN_USER_BITS-1:0]  i_s_tuser;   // [1:0] kind
    logic                     o_m_tvalid;
    logic                     i_m_tready;
    logic [OUT_DATA_BITS-1:0] o_m_tdata;   // [1:0] status, [64:2] new_handle,
                                           // [73:65] slot_index, [79:74] zero

    int             src_idle_pct = 0;
    int             snk_idle_pct = 0;
    bit             start_hold   = 1'b0;
    int             hold_left    = 0;
    int             idle_cycles  = 0;
    handle_table_sb sb;

    generational_handle_table_top uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic send_req(input logic [1:0] kind, input logic [63:0] handle);
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= kind;
        i_s_tdata  <= handle;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        sb.note_request(kind, handle);
    endtask

    // Mostly well-formed traffic against live handles, plus stale and junk handles
    task automatic issue_random(input int alloc_pct);
        logic [63:0]           h;
        logic [1:0]            k;
        logic [GEN_BITS-1:0]   g;
        logic [FIELD_BITS-1:0] f;
        int                    s;
        h = rand64();
        k = KIND_VALIDATE;
        if ($urandom_range(99) < alloc_pct) begin
            k = KIND_ALLOC;
        end else begin
            case ($urandom_range(9))
                0, 1, 2, 3: begin
                    h = sb.any_live_handle(h);
                end
                4, 5: begin
                    k = KIND_FREE;
                    h = sb.any_live_handle(h);
                end
                6: begin
                    // right slot, wrong generation
                    k = $urandom_range(1) ? KIND_FREE : KIND_VALIDATE;
                    s = $urandom_range(SLOTS - 1);
                    case ($urandom_range(2))
                        0:       g = sb.gen_of[s] + 1'b1;
                        1:       g = sb.gen_of[s] - 1'b1;
                        default: g = h[GEN_BITS-1:0];
                    endcase
                    h = make_handle(g, FIELD_BITS'(s + 1));
                end
                7: begin
                    k = $urandom_range(1) ? KIND_FREE : KIND_VALIDATE;
                    case ($urandom_range(3))
                        0:       f = '0;
                        1:       f = FIELD_BITS'(SLOTS + 1);
                        2:       f = FIELD_BITS'($urandom_range(2047, SLOTS + 1));
                        default: f = FIELD_BITS'($urandom_range(SLOTS, 1));
                    endcase
                    h = make_handle(GEN_BITS'($urandom_range(4, 1)), f);
                end
                8: begin
                    k = $urandom_range(1) ? KIND_FREE : KIND_VALIDATE;
                    case ($urandom_range(2))
                        0:       h = '0;
                        1: begin
                            h     = sb.any_live_handle(h);
                            h[63] = 1'b1;
                        end
                        default: h[63] = 1'b1;
                    endcase
                end
                default: begin
                    k = KIND_RSVD;
                    if ($urandom_range(1)) h = sb.any_live_handle(h);
                end
            endcase
        end
        send_req(k, h);
    endtask

    // Result side: random stalls, plus one long hold-off on request
    initial begin
        i_m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (start_hold) begin
                start_hold = 1'b0;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) sb.check_result(o_m_tdata);
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $error("no beat moved for %0d cycles, %0d results outstanding",
                   idle_cycles, sb.pending());
            $display("*** FAILED ***");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        sb = new();
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        i_s_tuser  <= KIND_ALLOC;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: junk handles on an empty table, then one slot's life cycle
        src_idle_pct = 11;
        snk_idle_pct = 77;
        send_req(KIND_VALIDATE, 64'h0);
        send_req(KIND_VALIDATE, 64'h8000_0000_0000_0000);
        send_req(KIND_FREE, '1);
        send_req(KIND_VALIDATE, 64'h7FFF_FFFF_FFFF_FFFF);
        send_req(KIND_RSVD, '0);
        send_req(KIND_RSVD, '1);
        send_req(KIND_ALLOC, '0);
        send_req(KIND_VALIDATE, make_handle(1, 1));
        send_req(KIND_VALIDATE, make_handle(0, 1));
        send_req(KIND_VALIDATE, make_handle(2, 1));
        send_req(KIND_VALIDATE, make_handle(1, 2));
        send_req(KIND_VALIDATE, make_handle(1, 0));
        send_req(KIND_FREE, make_handle(1, FIELD_BITS'(SLOTS + 1)));
        send_req(KIND_VALIDATE, make_handle(1, FIELD_BITS'(SLOTS)));
        send_req(KIND_VALIDATE, make_handle(1, '1));
        send_req(KIND_ALLOC, '1);
        send_req(KIND_FREE, make_handle(1, 1));
        send_req(KIND_FREE, make_handle(1, 1));
        send_req(KIND_VALIDATE, make_handle(1, 1));
        send_req(KIND_ALLOC, 64'h8000_0000_0000_0000);
        send_req(KIND_VALIDATE, make_handle(2, 1));
        send_req(KIND_VALIDATE, make_handle(GEN_MAX, 1));
        send_req(KIND_VALIDATE, make_handle(2, 1) | 64'h8000_0000_0000_0000);
        send_req(KIND_FREE, make_handle(1, 2));
        send_req(KIND_RSVD, make_handle(2, 1));

        repeat (500) issue_random(30);

        src_idle_pct = 77;
        snk_idle_pct = 11;
        repeat (500) issue_random(30);

        // No idling: long output hold-off, then fill the table past full and drain
        src_idle_pct = 0;
        snk_idle_pct = 0;
        start_hold   = 1'b1;
        repeat (560) issue_random(90);
        repeat (100) issue_random(8);
        i_s_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d requests: %0d allocs, %0d frees, peak %0d live slots",
                 sb.n_req, sb.n_alloc, sb.n_free, sb.peak_live);
        $display("results: %0d ok, %0d full, %0d exhausted, %0d unknown",
                 sb.n_status[ST_OK], sb.n_status[ST_FULL],
                 sb.n_status[ST_EXHAUSTED], sb.n_status[ST_UNKNOWN]);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
